// File: rtl/core/rcsfd_pkg.sv
`timescale 1ns / 1ps

package rcsfd_pkg;

	localparam int FRAME_LEN = 16;
	localparam int POS_W     = $clog2(FRAME_LEN + 1);
	localparam int NUM_CH    = 6;
	localparam int CH_W      = 10;
	localparam int DEV_W     = CH_W + 1;
	localparam int GAIN_W    = 24;
	localparam int FLOOR_W   = 16;
	localparam int LIMIT_W   = 8;
	localparam int CMD_W     = 16;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int Q_SHIFT   = 16;

	localparam logic [7:0] HDR_B0   = 8'h03;
	localparam logic [7:0] HDR_B1   = 8'hA2;
	localparam logic [7:0] TAG_MASK = 8'hFC;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// high byte position of each channel's slot pair, by channel number
	localparam int SLOT_HI [NUM_CH] = '{10, 2, 6, 8, 14, 4};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WATCHDOG_LIMIT = 3'd0,
		REG_HEAVE_GAIN     = 3'd1,
		REG_HEAVE_FLOOR    = 3'd2,
		REG_ROLL_GAIN      = 3'd3,
		REG_PITCH_GAIN     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic                    result_kind;
		logic [CMD_W-1:0]        heave_command;
		logic signed [CMD_W-1:0] roll_command;
		logic signed [CMD_W-1:0] pitch_command;
		logic                    closed_loop;
		logic                    motors_armed;
		logic                    link_open;
		logic                    comms_issue;
	} out_item_t;

	typedef struct packed {
		logic closed_loop;
		logic motors_armed;
		logic link_open;
		logic comms_issue;
	} flags_t;

	typedef struct packed {
		logic                    kind;
		logic [CH_W-1:0]         heave_ch;
		logic signed [DEV_W-1:0] roll_dev;
		logic signed [DEV_W-1:0] pitch_dev;
		flags_t                  flags;
	} job_t;

endpackage

// File: rtl/core/rcsfd_stream_if.sv
`timescale 1ns / 1ps

interface rcsfd_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/rc_serial_frame_decoder_unit.sv
`timescale 1ns / 1ps
// A word that yields a result passes the state update and job register,
// the gain multipliers, and the saturation and output register before it is shown.
// Throughput: one word per cycle when not stalled; words with no result only update state.
// The output register lets a new word in while a result waits to be taken.
// Reset (arst_n low, asynchronous) clears all control state and loads the register defaults.

module rc_serial_frame_decoder_unit
	import rcsfd_pkg::*;
#(
	parameter int ARM_HOLDOFF = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rcsfd_stream_if.sink         item,
	rcsfd_stream_if.source       result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [LIMIT_W-1:0] watchdog_limit_q;
	logic [GAIN_W-1:0]  heave_gain_q;
	logic [FLOOR_W-1:0] heave_floor_q;
	logic [GAIN_W-1:0]  roll_gain_q;
	logic [GAIN_W-1:0]  pitch_gain_q;

	logic               job_valid;
	logic               job_ready;
	job_t               job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watchdog_limit_q <= LIMIT_W'(5);
			heave_gain_q     <= GAIN_W'(65536);
			heave_floor_q    <= '0;
			roll_gain_q      <= GAIN_W'(65536);
			pitch_gain_q     <= GAIN_W'(65536);
		end else if (cfg_we) begin
			// drop writes to unknown indexes
			unique case (cfg_index)
				REG_WATCHDOG_LIMIT: watchdog_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_HEAVE_GAIN:     heave_gain_q     <= cfg_data[GAIN_W-1:0];
				REG_HEAVE_FLOOR:    heave_floor_q    <= cfg_data[FLOOR_W-1:0];
				REG_ROLL_GAIN:      roll_gain_q      <= cfg_data[GAIN_W-1:0];
				REG_PITCH_GAIN:     pitch_gain_q     <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rcsfd_frame #(
		.ARM_HOLDOFF(ARM_HOLDOFF)
	) u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (item.valid),
		.in_item        (item.payload),
		.in_ready       (item.ready),
		.watchdog_limit (watchdog_limit_q),
		.job_valid      (job_valid),
		.job            (job),
		.job_ready      (job_ready)
	);

	rcsfd_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (job),
		.job_ready   (job_ready),
		.heave_gain  (heave_gain_q),
		.heave_floor (heave_floor_q),
		.roll_gain   (roll_gain_q),
		.pitch_gain  (pitch_gain_q),
		.res_valid   (result.valid),
		.res_item    (result.payload),
		.res_ready   (result.ready)
	);

endmodule

// File: rtl/core/rcsfd_frame.sv
`timescale 1ns / 1ps

module rcsfd_frame
	import rcsfd_pkg::*;
#(
	parameter int ARM_HOLDOFF = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  in_item_t           in_item,
	output logic               in_ready,
	input  logic [LIMIT_W-1:0] watchdog_limit,
	output logic               job_valid,
	output job_t               job,
	input  logic               job_ready
);

	localparam int HOLD_W = $clog2(ARM_HOLDOFF + 1);
	localparam logic [HOLD_W-1:0] HOLD_MAX = HOLD_W'(ARM_HOLDOFF);

	logic [7:0]         bytes_q [FRAME_LEN];
	logic [POS_W-1:0]   pos_q;
	logic [CH_W-1:0]    chan_q [NUM_CH];
	logic [CH_W-1:0]    nom_q [NUM_CH];
	logic               taken_q;
	logic               loop_q;
	logic               armed_q;
	logic [HOLD_W-1:0]  hold_q;
	logic [LIMIT_W-1:0] tick_q;
	logic               open_q;
	logic               issue_q;
	logic               vld_s1;
	job_t               job_s1;

	logic               take;
	logic               is_byte;
	logic               is_tick;
	logic [POS_W-1:0]   pos_cur;
	logic               wr_byte;
	logic               frame_done;
	logic               good;
	logic [7:0]         view [FRAME_LEN];
	logic [CH_W-1:0]    chan_n [NUM_CH];
	logic [CH_W-1:0]    nom_e [NUM_CH];
	logic               loop_tgl;
	logic               arm_tgl;
	logic [HOLD_W-1:0]  hold_base;
	logic [HOLD_W:0]    hold_inc;
	logic [HOLD_W-1:0]  hold_n;
	logic [LIMIT_W-1:0] tick_inc;
	logic               lost;
	flags_t             flags_n;
	logic [LIMIT_W-1:0] tick_n;
	job_t               job_n;

	assign in_ready  = !vld_s1 || job_ready;
	assign take      = in_valid && in_ready;
	assign is_byte   = take && (in_item.kind == KIND_BYTE);
	assign is_tick   = take && (in_item.kind == KIND_TICK);
	assign job_valid = vld_s1;
	assign job       = job_s1;

	always_comb begin
		pos_cur    = in_item.frame_start ? '0 : pos_q;
		wr_byte    = is_byte && (pos_cur < POS_W'(FRAME_LEN));
		frame_done = wr_byte && (pos_cur == POS_W'(FRAME_LEN - 1));
		for (int i = 0; i < FRAME_LEN; i++) begin
			view[i] = (i == FRAME_LEN - 1) ? in_item.data_byte : bytes_q[i];
		end
		good = frame_done && (view[0] == HDR_B0) && (view[1] == HDR_B1);

		for (int c = 0; c < NUM_CH; c++) begin
			if ((view[SLOT_HI[c]] & TAG_MASK) == 8'(c << 2)) begin
				chan_n[c] = {view[SLOT_HI[c]][1:0], view[SLOT_HI[c] + 1]};
			end else begin
				chan_n[c] = chan_q[c];
			end
			nom_e[c] = taken_q ? nom_q[c] : chan_n[c];
		end

		loop_tgl  = chan_n[3] != nom_e[3];
		arm_tgl   = (chan_n[5] != nom_e[5]) && (hold_q == HOLD_MAX);
		hold_base = arm_tgl ? '0 : hold_q;
		hold_inc  = {1'b0, hold_base} + 1'b1;
		hold_n    = (hold_inc >= (HOLD_W + 1)'(ARM_HOLDOFF)) ? HOLD_MAX : hold_inc[HOLD_W-1:0];

		// saturate the tick count at its top
		tick_inc = (tick_q == '1) ? tick_q : tick_q + 1'b1;
		lost     = tick_inc >= watchdog_limit;

		flags_n.closed_loop  = good ? (loop_q ^ loop_tgl) : loop_q;
		flags_n.motors_armed = good ? (armed_q ^ arm_tgl) : armed_q;
		flags_n.link_open    = is_tick ? !lost : open_q;
		flags_n.comms_issue  = (is_tick && lost) ? 1'b1 : issue_q;

		if (is_tick) begin
			tick_n = lost ? watchdog_limit : tick_inc;
		end else if (frame_done) begin
			tick_n = '0;
		end else begin
			tick_n = tick_q;
		end

		job_n.kind      = in_item.kind;
		job_n.heave_ch  = is_tick ? '0 : chan_n[4];
		job_n.roll_dev  = is_tick ? '0 : DEV_W'(nom_e[1]) - DEV_W'(chan_n[1]);
		job_n.pitch_dev = is_tick ? '0 : DEV_W'(chan_n[2]) - DEV_W'(nom_e[2]);
		job_n.flags     = flags_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_W'(FRAME_LEN);
			taken_q <= 1'b0;
			loop_q  <= 1'b0;
			armed_q <= 1'b0;
			hold_q  <= HOLD_MAX;
			tick_q  <= '0;
			open_q  <= 1'b0;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				chan_q[c] <= '0;
				nom_q[c]  <= '0;
			end
		end else begin
			if (wr_byte) begin
				pos_q <= pos_cur + 1'b1;
			end
			tick_q  <= tick_n;
			open_q  <= flags_n.link_open;
			issue_q <= flags_n.comms_issue;
			if (good) begin
				for (int c = 0; c < NUM_CH; c++) begin
					chan_q[c] <= chan_n[c];
					nom_q[c]  <= nom_e[c];
				end
				// mode change re-latches the ch3 nominal
				nom_q[3] <= chan_n[3];
				taken_q  <= 1'b1;
				loop_q   <= flags_n.closed_loop;
				armed_q  <= flags_n.motors_armed;
				hold_q   <= hold_n;
			end
			if (in_ready) begin
				vld_s1 <= good || is_tick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_byte) begin
			bytes_q[pos_cur[POS_W-2:0]] <= in_item.data_byte;
		end
		if (in_ready && (good || is_tick)) begin
			job_s1 <= job_n;
		end
	end

endmodule

// File: rtl/core/rcsfd_scale.sv
`timescale 1ns / 1ps

module rcsfd_scale
	import rcsfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  job_t               job,
	output logic               job_ready,
	input  logic [GAIN_W-1:0]  heave_gain,
	input  logic [FLOOR_W-1:0] heave_floor,
	input  logic [GAIN_W-1:0]  roll_gain,
	input  logic [GAIN_W-1:0]  pitch_gain,
	output logic               res_valid,
	output out_item_t          res_item,
	input  logic               res_ready
);

	localparam int HP_W  = CH_W + GAIN_W;
	localparam int SP_W  = DEV_W + GAIN_W + 1;
	localparam int HS_W  = HP_W - Q_SHIFT;
	localparam int SS_W  = SP_W - Q_SHIFT;

	logic                   vld_s2;
	logic                   kind_s2;
	flags_t                 flags_s2;
	logic [HP_W-1:0]        heave_prod_s2;
	logic signed [SP_W-1:0] roll_prod_s2;
	logic signed [SP_W-1:0] pitch_prod_s2;
	logic                   vld_s3;
	out_item_t              res_s3;

	logic                   rdy2;
	logic                   rdy3;
	logic [HS_W-1:0]        heave_sh;
	logic [CMD_W-1:0]       heave_sat;
	logic [CMD_W-1:0]       heave_fl;
	out_item_t              res_n;

	function automatic logic [CMD_W-1:0] sat_cmd(input logic signed [SS_W-1:0] v);
		logic [SS_W-CMD_W:0] top;
		top = v[SS_W-1:CMD_W-1];
		if ((top == '0) || (top == '1)) begin
			sat_cmd = v[CMD_W-1:0];
		end else if (v[SS_W-1]) begin
			sat_cmd = {1'b1, {(CMD_W - 1){1'b0}}};
		end else begin
			sat_cmd = {1'b0, {(CMD_W - 1){1'b1}}};
		end
	endfunction

	assign rdy3      = !vld_s3 || res_ready;
	assign rdy2      = !vld_s2 || rdy3;
	assign job_ready = rdy2;
	assign res_valid = vld_s3;
	assign res_item  = res_s3;

	always_comb begin
		heave_sh  = heave_prod_s2[HP_W-1:Q_SHIFT];
		heave_sat = (|heave_sh[HS_W-1:CMD_W]) ? '1 : heave_sh[CMD_W-1:0];
		heave_fl  = (heave_sat < heave_floor) ? heave_floor : heave_sat;

		res_n.result_kind   = kind_s2;
		res_n.heave_command = (kind_s2 == KIND_TICK) ? '0 : heave_fl;
		// arithmetic shift rounds toward minus infinity
		res_n.roll_command  = sat_cmd(roll_prod_s2[SP_W-1:Q_SHIFT]);
		res_n.pitch_command = sat_cmd(pitch_prod_s2[SP_W-1:Q_SHIFT]);
		res_n.closed_loop   = flags_s2.closed_loop;
		res_n.motors_armed  = flags_s2.motors_armed;
		res_n.link_open     = flags_s2.link_open;
		res_n.comms_issue   = flags_s2.comms_issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy2) begin
				vld_s2 <= job_valid;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && job_valid) begin
			kind_s2       <= job.kind;
			flags_s2      <= job.flags;
			heave_prod_s2 <= HP_W'(job.heave_ch) * HP_W'(heave_gain);
			roll_prod_s2  <= SP_W'(job.roll_dev) * $signed(SP_W'(roll_gain));
			pitch_prod_s2 <= SP_W'(job.pitch_dev) * $signed(SP_W'(pitch_gain));
		end
		if (rdy3 && vld_s2) begin
			res_s3 <= res_n;
		end
	end

endmodule

// File: rtl/core/rcsfd_checker.sv
`timescale 1ns / 1ps

module rcsfd_checker
	import rcsfd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res
);

	// hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.result_kind == KIND_TICK) |->
			(res.heave_command == '0) && (res.roll_command == '0) &&
			(res.pitch_command == '0))
		else $error("status word carries nonzero commands");

	a_lost_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.result_kind == KIND_TICK) && !res.link_open |-> res.comms_issue)
		else $error("link lost without comms issue");

	a_issue_stays: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res.comms_issue ##1 res_valid |-> res.comms_issue)
		else $error("comms issue flag cleared");

endmodule

bind rc_serial_frame_decoder_unit rcsfd_checker u_rcsfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res       (result.payload)
);

// File: sim/rcsfd_frame_checker.sv
`timescale 1ns / 1ps

module rcsfd_frame_checker
	import rcsfd_pkg::*;
#(
	parameter int ARM_HOLDOFF = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  in_item_t             item_word,
	input  logic                 res_valid,
	input  logic                 res_ready,
	input  out_item_t            res_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   outstanding
);

	localparam logic RES_COMMAND = 1'b0;
	localparam logic RES_STATUS  = 1'b1;

	// register copies
	logic [LIMIT_W-1:0] wd_limit;
	logic [GAIN_W-1:0]  heave_gain, roll_gain, pitch_gain;
	logic [FLOOR_W-1:0] heave_floor;

	// decoder state
	logic [7:0]       frame_mem [FRAME_LEN];
	logic [POS_W-1:0] fill_pos;
	logic [CH_W-1:0]  chan_val [NUM_CH];
	logic [CH_W-1:0]  chan_nom [NUM_CH];
	logic             nom_taken, loop_on, armed, link_up, link_issue;
	int               holdoff;
	logic [7:0]       tick_cnt;

	out_item_t pending_results[$];

	function automatic logic signed [CMD_W-1:0] scale_dev(input longint dev,
			input logic [GAIN_W-1:0] gain);
		longint prod, q;
		prod = dev * longint'(gain);
		q = prod >>> Q_SHIFT;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[CMD_W-1:0];
	endfunction

	task automatic reset_model();
		wd_limit    = 8'd5;
		heave_gain  = 24'd65536;
		heave_floor = '0;
		roll_gain   = 24'd65536;
		pitch_gain  = 24'd65536;
		fill_pos    = POS_W'(FRAME_LEN);
		for (int c = 0; c < NUM_CH; c++) begin
			chan_val[c] = '0;
			chan_nom[c] = '0;
		end
		nom_taken  = 1'b0;
		loop_on    = 1'b0;
		armed      = 1'b0;
		link_up    = 1'b0;
		link_issue = 1'b0;
		holdoff    = ARM_HOLDOFF;
		tick_cnt   = '0;
		pending_results.delete();
	endtask

	task automatic put_flags(inout out_item_t r);
		r.closed_loop  = loop_on;
		r.motors_armed = armed;
		r.link_open    = link_up;
		r.comms_issue  = link_issue;
	endtask

	task automatic decode_word(input in_item_t w);
		out_item_t  r;
		longint     heave;
		logic [7:0] hi;
		r = '0;
		if (w.kind == KIND_TICK) begin
			if (tick_cnt != 8'hFF)
				tick_cnt++;
			if (tick_cnt >= wd_limit) begin
				link_up    = 1'b0;
				tick_cnt   = wd_limit;
				link_issue = 1'b1;
			end else begin
				link_up = 1'b1;
			end
			r.result_kind = RES_STATUS;
			put_flags(r);
			pending_results.push_back(r);
			return;
		end
		if (w.frame_start)
			fill_pos = '0;
		if (fill_pos >= POS_W'(FRAME_LEN))
			return;
		frame_mem[fill_pos[3:0]] = w.data_byte;
		fill_pos++;
		if (fill_pos < POS_W'(FRAME_LEN))
			return;
		tick_cnt = '0;
		if (frame_mem[0] != HDR_B0 || frame_mem[1] != HDR_B1)
			return;
		for (int c = 0; c < NUM_CH; c++) begin
			hi = frame_mem[SLOT_HI[c]];
			if ((hi & TAG_MASK) == 8'(c << 2))
				chan_val[c] = {hi[1:0], frame_mem[SLOT_HI[c] + 1]};
		end
		if (!nom_taken) begin
			for (int c = 0; c < NUM_CH; c++)
				chan_nom[c] = chan_val[c];
			nom_taken = 1'b1;
		end
		heave = (longint'(chan_val[4]) * longint'(heave_gain)) >>> Q_SHIFT;
		if (heave > 65535)
			heave = 65535;
		if (heave < longint'(heave_floor))
			heave = longint'(heave_floor);
		r.result_kind   = RES_COMMAND;
		r.heave_command = heave[CMD_W-1:0];
		r.roll_command  = scale_dev(-(longint'(chan_val[1]) - longint'(chan_nom[1])), roll_gain);
		r.pitch_command = scale_dev(longint'(chan_val[2]) - longint'(chan_nom[2]), pitch_gain);
		// a moved mode switch flips the loop and becomes the new rest position
		if (chan_val[3] != chan_nom[3]) begin
			loop_on     = ~loop_on;
			chan_nom[3] = chan_val[3];
		end
		if (chan_val[5] != chan_nom[5] && holdoff == ARM_HOLDOFF) begin
			armed   = ~armed;
			holdoff = 0;
		end
		holdoff++;
		if (holdoff >= ARM_HOLDOFF)
			holdoff = ARM_HOLDOFF;
		put_flags(r);
		pending_results.push_back(r);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			$error("result word with nothing expected: kind %0d heave %0d",
				got.result_kind, got.heave_command);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		check_field("result_kind", longint'(want.result_kind), longint'(got.result_kind));
		check_field("heave_command", longint'(want.heave_command),
			longint'(got.heave_command));
		check_field("roll_command", longint'($signed(want.roll_command)),
			longint'($signed(got.roll_command)));
		check_field("pitch_command", longint'($signed(want.pitch_command)),
			longint'($signed(got.pitch_command)));
		check_field("closed_loop", longint'(want.closed_loop), longint'(got.closed_loop));
		check_field("motors_armed", longint'(want.motors_armed), longint'(got.motors_armed));
		check_field("link_open", longint'(want.link_open), longint'(got.link_open));
		check_field("comms_issue", longint'(want.comms_issue), longint'(got.comms_issue));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			fail_count  = 0;
			outstanding = 0;
		end else begin
			// a result leaves only after its word has passed the job and pipeline registers, so pop before pushing
			if (res_valid && res_ready)
				check_result(res_word);
			if (cfg_we) begin
				case (cfg_index)
					REG_WATCHDOG_LIMIT: wd_limit    = cfg_data[LIMIT_W-1:0];
					REG_HEAVE_GAIN:     heave_gain  = cfg_data[GAIN_W-1:0];
					REG_HEAVE_FLOOR:    heave_floor = cfg_data[FLOOR_W-1:0];
					REG_ROLL_GAIN:      roll_gain   = cfg_data[GAIN_W-1:0];
					REG_PITCH_GAIN:     pitch_gain  = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				decode_word(item_word);
			outstanding = pending_results.size();
		end
	end

endmodule

// File: sim/rc_serial_frame_decoder_unit_test.sv
`timescale 1ns / 1ps

module rc_serial_frame_decoder_unit_test;
	import rcsfd_pkg::*;

	localparam int ARM_HOLD     = 25;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef logic [FRAME_LEN-1:0][7:0]  frame_t;
	typedef logic [NUM_CH-1:0][CH_W-1:0] stick_t;

	logic                 clk    = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int     fail_count, outstanding;
	int     cycle_count = 0;
	int     burst_left  = 0;
	int     words_sent  = 0;
	int     stall_mode  = 0;
	int     mode_left   = 0;
	stick_t stick = '0;

	rcsfd_stream_if #(.payload_t(in_item_t))  item_ch();
	rcsfd_stream_if #(.payload_t(out_item_t)) result_ch();

	rc_serial_frame_decoder_unit #(.ARM_HOLDOFF(ARM_HOLD)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rcsfd_frame_checker #(.ARM_HOLDOFF(ARM_HOLD)) frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_ch.valid),
		.item_ready  (item_ch.ready),
		.item_word   (item_ch.payload),
		.res_valid   (result_ch.valid),
		.res_ready   (result_ch.ready),
		.res_word    (result_ch.payload),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: switch between always ready, coin flips, long stalls and toggling
	always @(negedge clk) begin
		if (mode_left == 0) begin
			mode_left  = $urandom_range(4, 60);
			stall_mode = $urandom_range(0, 3);
		end
		mode_left--;
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= 1'($urandom_range(0, 1));
			2: result_ch.ready <= ($urandom_range(0, 7) == 0);
			default: result_ch.ready <= ~result_ch.ready;
		endcase
	end

	function automatic in_item_t byte_word(input logic [7:0] b, input logic first);
		in_item_t w;
		w.kind        = KIND_BYTE;
		w.data_byte   = b;
		w.frame_start = first;
		return w;
	endfunction

	function automatic frame_t make_frame(input stick_t v, input logic [5:0] bad_tags);
		frame_t     f;
		logic [5:0] tag;
		for (int i = 0; i < FRAME_LEN; i++)
			f[i] = 8'($urandom_range(0, 255));
		f[0] = HDR_B0;
		f[1] = HDR_B1;
		for (int c = 0; c < NUM_CH; c++) begin
			tag = 6'(c);
			if (bad_tags[c])
				tag = tag ^ 6'($urandom_range(1, 63));
			f[SLOT_HI[c]]     = {tag, v[c][9:8]};
			f[SLOT_HI[c] + 1] = v[c][7:0];
		end
		return f;
	endfunction

	// send in bursts; a gap only opens between bursts
	task automatic send_word(input in_item_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			repeat (gap) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.payload <= w;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_frame(input frame_t f, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			send_word(byte_word(f[i], i == 0));
	endtask

	task automatic send_ticks(input int n);
		in_item_t w;
		w.kind        = KIND_TICK;
		w.frame_start = 1'b0;
		repeat (n) begin
			w.data_byte = 8'($urandom_range(0, 255));
			send_word(w);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic program_regs(input int lim, input int hgain, input int hfloor,
			input int rgain, input int pgain);
		write_reg(REG_WATCHDOG_LIMIT, CFG_W'(lim));
		write_reg(REG_HEAVE_GAIN, CFG_W'(hgain));
		write_reg(REG_HEAVE_FLOOR, CFG_W'(hfloor));
		write_reg(REG_ROLL_GAIN, CFG_W'(rgain));
		write_reg(REG_PITCH_GAIN, CFG_W'(pgain));
		write_reg(REG_UNMAPPED, CFG_W'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every result is back, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic roll_sticks();
		for (int c = 0; c < NUM_CH; c++) begin
			if (c == 3 || c == 5) begin
				if ($urandom_range(0, 5) == 0)
					stick[c] = CH_W'($urandom_range(0, 1023));
			end else begin
				case ($urandom_range(0, 5))
					0: stick[c] = '0;
					1: stick[c] = '1;
					2: stick[c] = CH_W'($urandom_range(0, 1023));
					3: stick[c] = stick[c] + CH_W'($urandom_range(0, 40)) - CH_W'(20);
					default: ;
				endcase
			end
		end
	endtask

	task automatic directed();
		frame_t f;
		send_word(byte_word(HDR_B0, 1'b0));
		send_ticks(1);
		stick[0] = 10'd512;
		stick[1] = 10'd512;
		stick[2] = 10'd512;
		stick[3] = 10'd300;
		stick[4] = 10'd1023;
		stick[5] = 10'd100;
		send_frame(make_frame(stick, '0), FRAME_LEN);
		// drop a partial frame, then restart
		send_frame(make_frame(stick, '0), 5);
		stick[1] = '0;
		stick[2] = '1;
		stick[3] = 10'd301;
		stick[4] = '0;
		stick[5] = 10'd101;
		send_frame(make_frame(stick, '0), FRAME_LEN);
		// arm switch back inside the holdoff
		stick[1] = '1;
		stick[2] = '0;
		stick[5] = 10'd100;
		send_frame(make_frame(stick, '0), FRAME_LEN);
		f = make_frame(stick, '0);
		f[1] = HDR_B1 ^ 8'h01;
		send_frame(f, FRAME_LEN);
		send_frame(make_frame(stick, '1), FRAME_LEN);
		send_ticks(4);
		send_frame(make_frame(stick, '0), FRAME_LEN);
		send_ticks(1);
	endtask

	task automatic random_traffic(input int n_words);
		int         first, r, k;
		frame_t     f;
		logic [5:0] bad;
		in_item_t   w;
		first = words_sent;
		while (words_sent - first < n_words) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				roll_sticks();
				bad = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'd0;
				send_frame(make_frame(stick, bad), FRAME_LEN);
			end else if (r < 72) begin
				send_ticks($urandom_range(1, 6));
			end else if (r < 80) begin
				roll_sticks();
				f = make_frame(stick, '0);
				k = $urandom_range(0, 1);
				f[k] = f[k] ^ 8'($urandom_range(1, 255));
				send_frame(f, FRAME_LEN);
			end else if (r < 88) begin
				send_frame(make_frame(stick, '0), $urandom_range(1, FRAME_LEN - 1));
			end else if (r < 94) begin
				repeat ($urandom_range(1, 4))
					send_word(byte_word(8'($urandom_range(0, 255)), 1'b0));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					w = 10'($urandom);
					send_word(w);
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		program_regs(3, 65536, 100, 65536, 65536);
		directed();
		settle();

		program_regs(255, 16777215, 65535, 16777215, 16777215);
		send_ticks(260);
		random_traffic(100);
		settle();

		program_regs(1, 0, 0, 0, 0);
		random_traffic(100);
		settle();

		program_regs($urandom_range(2, 12), $urandom_range(0, 1 << 18),
			$urandom_range(0, 3000), $urandom_range(0, 1 << 18),
			$urandom_range(0, 1 << 18));
		random_traffic(115);
		settle();

		program_regs($urandom_range(1, 255), $urandom_range(0, 16777215),
			$urandom_range(0, 65535), $urandom_range(0, 16777215),
			$urandom_range(0, 16777215));
		random_traffic(115);
		settle();

		if (fail_count == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
